// ----- rtl/dci_pkg.sv -----
// Shared types, constants and step functions for the disc collision impulse unit.
package dci_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NORM_BITS = 30;
    localparam int IN_BITS = 384;
    localparam int OUT_BITS = 8 * WORD_BITS;
    localparam int SQRT_STAGES = WORD_BITS;
    localparam int DIV_STAGES = NORM_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CFG_BITS = 17;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RESTITUTION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DISTANCE = 2'd1;
    localparam logic [CFG_BITS-1:0] RESTITUTION_RESET = 17'd32768;
    localparam logic [CFG_BITS-1:0] MIN_DISTANCE_RESET = 17'd66;

    typedef enum logic [2:0] {
        ST_NO_OVERLAP = 3'd0,
        ST_COINCIDENT = 3'd1,
        ST_SEPARATING = 3'd2,
        ST_RESOLVED   = 3'd3,
        ST_ZERO_MASS  = 3'd4
    } status_t;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t       ax;
        word_t       ay;
        word_t       avx;
        word_t       avy;
        word_t       bx;
        word_t       by;
        word_t       bvx;
        word_t       bvy;
        logic [31:0] rsum;
        logic [30:0] ma;
        logic [30:0] mb;
        logic [31:0] ux;
        logic [31:0] uy;
        logic        sgx;
        logic        sgy;
        status_t     status;
        logic        live;
    } disc_t;

    typedef struct packed {
        disc_t       d;
        logic [31:0] distance;
    } qent_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sq_t;

    // one digit of the integer square root, k counts from the top digit
    function automatic sq_t sq_step(input sq_t s, input int unsigned k);
        sq_t         r;
        logic [63:0] b;
        logic [63:0] t;
        b = 64'd1 << (62 - 2 * k);
        t = s.res + b;
        if (s.n >= t)
        begin
            r.n = s.n - t;
            r.res = (s.res >> 1) + b;
        end
        else
        begin
            r.n = s.n;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    // restoring divide step: acc = {rem[32:0], dividend bits / quotient bits[30:0]}
    function automatic logic [63:0] div_step(input logic [63:0] acc, input logic [31:0] dv);
        logic [32:0] r;
        logic [30:0] low;
        r = acc[62:30];
        low = {acc[29:0], 1'b0};
        if (r >= {1'b0, dv})
        begin
            r = r - {1'b0, dv};
            low[0] = 1'b1;
        end
        return {r, low};
    endfunction

endpackage

// ----- rtl/disc_collision_impulse_unit.sv -----
// Top level of the disc collision impulse unit: config registers, front, queue, back.
// Throughput: one pair per cycle while neither the queue nor the output stalls;
// the front root pipeline (32 stages) and the back divider pipeline (31 stages)
// are fully pipelined, one digit per stage.
// A four-entry queue separates front and back so each side stalls on its own.
// Reset clears all valid state and sets restitution to 0.5 and min_distance to 66.
module disc_collision_impulse_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // a_x, a_y, a_vx, a_vy, a_radius, a_mass, b_x, b_y, b_vx, b_vy, b_radius, b_mass, pad
    input  logic [dci_pkg::IN_BITS-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // new_a_x, new_a_y, new_a_vx, new_a_vy, new_b_x, new_b_y, new_b_vx, new_b_vy
    output logic [dci_pkg::OUT_BITS-1:0]     m_axis_tdata,
    // status
    output logic [2:0]                       m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dci_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [dci_pkg::CFG_BITS-1:0]     cfg_data
);

    logic [dci_pkg::CFG_BITS-1:0] restitution_reg;
    logic [dci_pkg::CFG_BITS-1:0] min_distance_reg;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    dci_pkg::qent_t q_in;
    dci_pkg::qent_t q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= dci_pkg::RESTITUTION_RESET;
            min_distance_reg <= dci_pkg::MIN_DISTANCE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dci_pkg::CFG_RESTITUTION: restitution_reg <= cfg_data;
                dci_pkg::CFG_MIN_DISTANCE: min_distance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dci_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_data      (s_axis_tdata),
        .min_distance (min_distance_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    dci_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    dci_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_out),
        .restitution (restitution_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_status  (m_axis_tuser)
    );

endmodule

// ----- rtl/dci_front.sv -----
// Front part: accepts disc pairs, tests overlap, takes the distance root, flags coincidence.
module dci_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dci_pkg::IN_BITS-1:0]  in_data,
    input  logic [dci_pkg::CFG_BITS-1:0] min_distance,
    input  logic                         q_full,
    output logic                         q_push,
    output dci_pkg::qent_t               q_data
);

    localparam int SS = dci_pkg::SQRT_STAGES;
    localparam int FS = 3 + SS;

    logic           en;
    logic [FS-1:0]  vld_reg;
    dci_pkg::disc_t d0_next;
    dci_pkg::disc_t d0_reg;
    dci_pkg::disc_t d1_reg;
    dci_pkg::disc_t d2_next;
    dci_pkg::disc_t d2_reg;
    logic [63:0]    sx_reg;
    logic [63:0]    sy_reg;
    logic [63:0]    rr_reg;
    logic [64:0]    dsq;
    logic [63:0]    n2_reg;
    dci_pkg::sq_t   sq_reg [SS];
    dci_pkg::disc_t ds_reg [SS];
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]    ux_w;
    logic [32:0]    uy_w;
    logic [31:0]    distance;

    assign en = !vld_reg[FS-1] || !q_full;
    assign in_ready = en;
    assign q_push = vld_reg[FS-1] && !q_full;

    always_comb
    begin
        d0_next.ax = in_data[31:0];
        d0_next.ay = in_data[63:32];
        d0_next.avx = in_data[95:64];
        d0_next.avy = in_data[127:96];
        d0_next.bx = in_data[221:190];
        d0_next.by = in_data[253:222];
        d0_next.bvx = in_data[285:254];
        d0_next.bvy = in_data[317:286];
        d0_next.ma = in_data[189:159];
        d0_next.mb = in_data[379:349];
        d0_next.rsum = {1'b0, in_data[158:128]} + {1'b0, in_data[348:318]};
        dx = {d0_next.ax[31], d0_next.ax} - {d0_next.bx[31], d0_next.bx};
        dy = {d0_next.ay[31], d0_next.ay} - {d0_next.by[31], d0_next.by};
        ux_w = dx[32] ? 33'(-dx) : 33'(dx);
        uy_w = dy[32] ? 33'(-dy) : 33'(dy);
        d0_next.ux = ux_w[31:0];
        d0_next.uy = uy_w[31:0];
        d0_next.sgx = dx[32];
        d0_next.sgy = dy[32];
        d0_next.status = dci_pkg::ST_NO_OVERLAP;
        d0_next.live = (d0_next.ux < d0_next.rsum) && (d0_next.uy < d0_next.rsum);
    end

    always_comb
    begin
        dsq = {1'b0, sx_reg} + {1'b0, sy_reg};
        d2_next = d1_reg;
        d2_next.live = d1_reg.live && (dsq < {1'b0, rr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg <= d0_next;
            d1_reg <= d0_reg;
            sx_reg <= d0_reg.ux * d0_reg.ux;
            sy_reg <= d0_reg.uy * d0_reg.uy;
            rr_reg <= d0_reg.rsum * d0_reg.rsum;
            d2_reg <= d2_next;
            n2_reg <= dsq[63:0];
            sq_reg[0] <= dci_pkg::sq_step('{n: n2_reg, res: 64'd0}, 0);
            ds_reg[0] <= d2_reg;
            for (int unsigned k = 1; k < SS; k++)
            begin
                sq_reg[k] <= dci_pkg::sq_step(sq_reg[k-1], k);
                ds_reg[k] <= ds_reg[k-1];
            end
        end
    end

    assign distance = sq_reg[SS-1].res[31:0];

    always_comb
    begin
        q_data.d = ds_reg[SS-1];
        q_data.distance = distance;
        if (ds_reg[SS-1].live && (distance == 32'd0 || distance < {15'd0, min_distance}))
        begin
            q_data.d.status = dci_pkg::ST_COINCIDENT;
            q_data.d.live = 1'b0;
        end
    end

endmodule

// ----- rtl/dci_queue.sv -----
// Short item queue between the front and back parts.
module dci_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dci_pkg::qent_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output dci_pkg::qent_t pop_data
);

    localparam int PB = dci_pkg::QPTR_BITS;

    dci_pkg::qent_t mem_reg [dci_pkg::QUEUE_DEPTH];
    logic [PB-1:0]  wr_ptr_reg;
    logic [PB-1:0]  rd_ptr_reg;
    logic [PB:0]    count_reg;
    logic           do_push;
    logic           do_pop;

    assign full = (count_reg == (PB+1)'(dci_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop = pop && valid;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/dci_back.sv -----
// Back part: normal and mass shares by division, impulse and push-apart, saturation.
module dci_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  dci_pkg::qent_t                q_data,
    input  logic [dci_pkg::CFG_BITS-1:0]  restitution,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dci_pkg::OUT_BITS-1:0]  out_data,
    output logic [2:0]                    out_status
);

    localparam int DS = dci_pkg::DIV_STAGES;
    localparam int NB = dci_pkg::NORM_BITS;
    localparam int VS = DS + 6;
    localparam logic [30:0] NORM_ONE = 31'd1 << NB;

    typedef struct packed {
        dci_pkg::disc_t d;
        logic [31:0]    distance;
        logic [31:0]    pen;
        logic [31:0]    msum;
        logic [31:0]    rxm;
        logic [31:0]    rym;
        logic           rxs;
        logic           rys;
    } bk_t;

    typedef struct packed {
        logic [30:0] nxm;
        logic [30:0] nym;
        logic [30:0] wa;
        logic [30:0] wb;
    } nrm_t;

    logic          enb;
    logic [VS-1:0] vld_reg;
    logic          out_vld_reg;
    bk_t           b0_next;
    bk_t           b0_reg;
    bk_t           dv_bk_reg [DS];
    logic [63:0]   acc_reg [DS][4];
    logic [63:0]   acc_init [4];
    logic [31:0]   dvsr [4];
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic [32:0]   rxm_w;
    logic [32:0]   rym_w;

    bk_t           v1_bk_reg;
    nrm_t          v1_nm_reg;
    nrm_t          v1_nm_next;
    logic [62:0]   tx_reg;
    logic [62:0]   ty_reg;

    bk_t           v2_bk_reg;
    bk_t           v2_bk_next;
    nrm_t          v2_nm_reg;
    logic signed [34:0] vn;
    logic [34:0]   negvn_reg;

    bk_t           v3_bk_reg;
    nrm_t          v3_nm_reg;
    logic [52:0]   kp;
    logic [36:0]   k_reg;
    logic [62:0]   pap;
    logic [62:0]   pbp;
    logic [32:0]   pa_reg;
    logic [32:0]   pb_reg;
    logic [17:0]   fac;

    bk_t           v4_bk_reg;
    nrm_t          v4_nm_reg;
    logic [67:0]   kap;
    logic [67:0]   kbp;
    logic [36:0]   ka_reg;
    logic [36:0]   kb_reg;
    logic [32:0]   pa4_reg;
    logic [32:0]   pb4_reg;

    bk_t           v5_bk_reg;
    logic [37:0]   dm_reg [8];

    dci_pkg::word_t res_next [8];
    logic [dci_pkg::OUT_BITS-1:0] out_data_reg;
    logic [2:0]    out_status_reg;

    function automatic dci_pkg::word_t apply_delta(input dci_pkg::word_t v,
                                                   input logic [37:0] m,
                                                   input logic neg);
        logic signed [39:0] s;
        logic signed [39:0] dd;
        dd = $signed({2'b00, m});
        s = 40'(v) + (neg ? -dd : dd);
        if (s > 40'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (s < -40'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    function automatic logic [30:0] clamp_norm(input logic [30:0] q);
        return (q > NORM_ONE) ? NORM_ONE : q;
    endfunction

    assign enb = !out_vld_reg || out_ready;
    assign q_pop = enb && q_valid;
    assign out_valid = out_vld_reg;
    assign out_data = out_data_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        b0_next.d = q_data.d;
        b0_next.distance = q_data.distance;
        b0_next.pen = q_data.d.rsum - q_data.distance;
        b0_next.msum = {1'b0, q_data.d.ma} + {1'b0, q_data.d.mb};
        rx = {q_data.d.avx[31], q_data.d.avx} - {q_data.d.bvx[31], q_data.d.bvx};
        ry = {q_data.d.avy[31], q_data.d.avy} - {q_data.d.bvy[31], q_data.d.bvy};
        rxm_w = rx[32] ? 33'(-rx) : 33'(rx);
        rym_w = ry[32] ? 33'(-ry) : 33'(ry);
        b0_next.rxm = rxm_w[31:0];
        b0_next.rym = rym_w[31:0];
        b0_next.rxs = rx[32];
        b0_next.rys = ry[32];
    end

    always_comb
    begin
        acc_init[0] = {2'b00, b0_reg.d.ux, 30'd0};
        acc_init[1] = {2'b00, b0_reg.d.uy, 30'd0};
        acc_init[2] = {3'b000, b0_reg.d.mb, 30'd0};
        acc_init[3] = {3'b000, b0_reg.d.ma, 30'd0};
        dvsr[0] = b0_reg.distance;
        dvsr[1] = b0_reg.distance;
        dvsr[2] = b0_reg.msum;
        dvsr[3] = b0_reg.msum;
    end

    always_comb
    begin
        v1_nm_next.nxm = clamp_norm(acc_reg[DS-1][0][30:0]);
        v1_nm_next.nym = clamp_norm(acc_reg[DS-1][1][30:0]);
        v1_nm_next.wa = clamp_norm(acc_reg[DS-1][2][30:0]);
        v1_nm_next.wb = clamp_norm(acc_reg[DS-1][3][30:0]);
    end

    always_comb
    begin
        logic signed [34:0] tx_s;
        logic signed [34:0] ty_s;
        tx_s = $signed({2'b00, tx_reg[62:30]});
        ty_s = $signed({2'b00, ty_reg[62:30]});
        vn = ((v1_bk_reg.d.sgx ^ v1_bk_reg.rxs) ? -tx_s : tx_s)
           + ((v1_bk_reg.d.sgy ^ v1_bk_reg.rys) ? -ty_s : ty_s);
        v2_bk_next = v1_bk_reg;
        if (v1_bk_reg.d.live)
        begin
            if (vn > 35'sd0)
            begin
                v2_bk_next.d.status = dci_pkg::ST_SEPARATING;
                v2_bk_next.d.live = 1'b0;
            end
            else if (v1_bk_reg.d.ma == 31'd0 || v1_bk_reg.d.mb == 31'd0)
            begin
                v2_bk_next.d.status = dci_pkg::ST_ZERO_MASS;
                v2_bk_next.d.live = 1'b0;
            end
        end
    end

    assign fac = 18'(1 << dci_pkg::FRAC_BITS) + {1'b0, restitution};
    assign kp = negvn_reg * fac;
    assign pap = v2_bk_reg.pen * v2_nm_reg.wa;
    assign pbp = v2_bk_reg.pen * v2_nm_reg.wb;
    assign kap = k_reg * v3_nm_reg.wa;
    assign kbp = k_reg * v3_nm_reg.wb;

    always_comb
    begin
        res_next[0] = apply_delta(v5_bk_reg.d.ax, dm_reg[0], v5_bk_reg.d.sgx);
        res_next[1] = apply_delta(v5_bk_reg.d.ay, dm_reg[1], v5_bk_reg.d.sgy);
        res_next[2] = apply_delta(v5_bk_reg.d.avx, dm_reg[2], v5_bk_reg.d.sgx);
        res_next[3] = apply_delta(v5_bk_reg.d.avy, dm_reg[3], v5_bk_reg.d.sgy);
        res_next[4] = apply_delta(v5_bk_reg.d.bx, dm_reg[4], !v5_bk_reg.d.sgx);
        res_next[5] = apply_delta(v5_bk_reg.d.by, dm_reg[5], !v5_bk_reg.d.sgy);
        res_next[6] = apply_delta(v5_bk_reg.d.bvx, dm_reg[6], !v5_bk_reg.d.sgx);
        res_next[7] = apply_delta(v5_bk_reg.d.bvy, dm_reg[7], !v5_bk_reg.d.sgy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (enb)
        begin
            vld_reg <= {vld_reg[VS-2:0], q_valid};
            out_vld_reg <= vld_reg[VS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (enb)
        begin
            b0_reg <= b0_next;
            dv_bk_reg[0] <= b0_reg;
            for (int j = 0; j < 4; j++)
            begin
                acc_reg[0][j] <= dci_pkg::div_step(acc_init[j], dvsr[j]);
            end
            for (int k = 1; k < DS; k++)
            begin
                dv_bk_reg[k] <= dv_bk_reg[k-1];
                acc_reg[k][0] <= dci_pkg::div_step(acc_reg[k-1][0], dv_bk_reg[k-1].distance);
                acc_reg[k][1] <= dci_pkg::div_step(acc_reg[k-1][1], dv_bk_reg[k-1].distance);
                acc_reg[k][2] <= dci_pkg::div_step(acc_reg[k-1][2], dv_bk_reg[k-1].msum);
                acc_reg[k][3] <= dci_pkg::div_step(acc_reg[k-1][3], dv_bk_reg[k-1].msum);
            end

            v1_bk_reg <= dv_bk_reg[DS-1];
            v1_nm_reg <= v1_nm_next;
            tx_reg <= v1_nm_next.nxm * dv_bk_reg[DS-1].rxm;
            ty_reg <= v1_nm_next.nym * dv_bk_reg[DS-1].rym;

            v2_bk_reg <= v2_bk_next;
            v2_nm_reg <= v1_nm_reg;
            negvn_reg <= 35'(-vn);

            v3_bk_reg <= v2_bk_reg;
            v3_nm_reg <= v2_nm_reg;
            k_reg <= kp[52:16];
            pa_reg <= pap[62:30];
            pb_reg <= pbp[62:30];

            v4_bk_reg <= v3_bk_reg;
            v4_nm_reg <= v3_nm_reg;
            ka_reg <= kap[66:30];
            kb_reg <= kbp[66:30];
            pa4_reg <= pa_reg;
            pb4_reg <= pb_reg;

            v5_bk_reg <= v4_bk_reg;
            dm_reg[0] <= 38'((68'(v4_nm_reg.nxm) * 68'(pa4_reg)) >> NB);
            dm_reg[1] <= 38'((68'(v4_nm_reg.nym) * 68'(pa4_reg)) >> NB);
            dm_reg[2] <= 38'((68'(v4_nm_reg.nxm) * 68'(ka_reg)) >> NB);
            dm_reg[3] <= 38'((68'(v4_nm_reg.nym) * 68'(ka_reg)) >> NB);
            dm_reg[4] <= 38'((68'(v4_nm_reg.nxm) * 68'(pb4_reg)) >> NB);
            dm_reg[5] <= 38'((68'(v4_nm_reg.nym) * 68'(pb4_reg)) >> NB);
            dm_reg[6] <= 38'((68'(v4_nm_reg.nxm) * 68'(kb_reg)) >> NB);
            dm_reg[7] <= 38'((68'(v4_nm_reg.nym) * 68'(kb_reg)) >> NB);

            if (v5_bk_reg.d.live)
            begin
                out_data_reg <= {res_next[7], res_next[6], res_next[5], res_next[4],
                                 res_next[3], res_next[2], res_next[1], res_next[0]};
                out_status_reg <= dci_pkg::ST_RESOLVED;
            end
            else
            begin
                out_data_reg <= {v5_bk_reg.d.bvy, v5_bk_reg.d.bvx, v5_bk_reg.d.by,
                                 v5_bk_reg.d.bx, v5_bk_reg.d.avy, v5_bk_reg.d.avx,
                                 v5_bk_reg.d.ay, v5_bk_reg.d.ax};
                out_status_reg <= v5_bk_reg.d.status;
            end
        end
    end

endmodule

// ----- rtl/dci_checker.sv -----
// Port-level checks for the disc collision impulse unit, bound to the top level.
module dci_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [2:0] m_axis_tuser,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("result dropped or changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= 3'(dci_pkg::ST_ZERO_MASS))
        else $error("status code out of range");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

    a_reset_state: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

bind disc_collision_impulse_unit dci_checker u_dci_checker (.*);

// ----- test/disc_collision_impulse_unit_tb.sv -----
// Self-checking testbench for the disc collision impulse unit.
module disc_collision_impulse_unit_tb;
    import dci_pkg::*;

    localparam longint unsigned MAG_LIMIT = 64'd1 << 62;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 90;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        word_t       ax, ay, avx, avy;
        logic [30:0] ar, am;
        word_t       bx, by, bvx, bvy;
        logic [30:0] br, bm;
    } disc_pair_t;

    typedef struct {
        word_t   w[8];
        status_t status;
    } contact_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_BITS-1:0]      s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_BITS-1:0]     m_axis_tdata;
    logic [2:0]              m_axis_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    contact_result_t pending_results[$];
    logic [CFG_BITS-1:0] restitution_q;
    logic [CFG_BITS-1:0] min_dist_q;
    int mismatches = 0;
    int cycles = 0;
    int burst_left;
    bit gaps_on;
    bit stall_on;
    bit hold_kick;
    int hold_count = 0;

    disc_collision_impulse_unit DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                               input int unsigned s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        if (p > 128'(MAG_LIMIT))
            return MAG_LIMIT;
        return p[63:0];
    endfunction

    function automatic longint smul_shift(input longint a, input longint b,
                                          input int unsigned s);
        logic [63:0] r;
        r = mul_shift(magnitude(a), magnitude(b), s);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_comp(input longint d, input logic [63:0] distance);
        logic [63:0] q;
        q = (magnitude(d) << NORM_BITS) / distance;
        if (q > (64'd1 << NORM_BITS))
            q = 64'd1 << NORM_BITS;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic word_t clamp_word(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return word_t'(v);
    endfunction

    function automatic contact_result_t predict_contact(input disc_pair_t p);
        contact_result_t r;
        longint v[8];
        longint dx, dy, nx, ny, rx, ry, vn, ka, kb, pa, pb;
        logic [63:0] ux, uy, rsum, sx, sy, dsq, distance, msum, wa, wb, k, pen;
        v[0] = p.ax; v[1] = p.ay; v[2] = p.avx; v[3] = p.avy;
        v[4] = p.bx; v[5] = p.by; v[6] = p.bvx; v[7] = p.bvy;
        r.status = ST_NO_OVERLAP;
        dx = v[0] - v[4];
        dy = v[1] - v[5];
        ux = magnitude(dx);
        uy = magnitude(dy);
        rsum = 64'(p.ar) + 64'(p.br);
        if (ux < rsum && uy < rsum)
        begin
            sx = ux * ux;
            sy = uy * uy;
            dsq = sx + sy;
            if (dsq >= sx && dsq < rsum * rsum)
            begin
                distance = int_sqrt(dsq);
                if (distance == 0 || distance < 64'(min_dist_q))
                    r.status = ST_COINCIDENT;
                else
                begin
                    nx = unit_comp(dx, distance);
                    ny = unit_comp(dy, distance);
                    rx = v[2] - v[6];
                    ry = v[3] - v[7];
                    vn = smul_shift(nx, rx, NORM_BITS) + smul_shift(ny, ry, NORM_BITS);
                    if (vn > 0)
                        r.status = ST_SEPARATING;
                    else if (p.am == 0 || p.bm == 0)
                        r.status = ST_ZERO_MASS;
                    else
                    begin
                        msum = 64'(p.am) + 64'(p.bm);
                        wa = (64'(p.bm) << NORM_BITS) / msum;
                        wb = (64'(p.am) << NORM_BITS) / msum;
                        k = mul_shift(64'(-vn), (64'd1 << FRAC_BITS) + 64'(restitution_q),
                                      FRAC_BITS);
                        pen = rsum - distance;
                        ka = longint'(mul_shift(k, wa, NORM_BITS));
                        kb = longint'(mul_shift(k, wb, NORM_BITS));
                        pa = longint'(mul_shift(pen, wa, NORM_BITS));
                        pb = longint'(mul_shift(pen, wb, NORM_BITS));
                        v[0] = v[0] + smul_shift(nx, pa, NORM_BITS);
                        v[1] = v[1] + smul_shift(ny, pa, NORM_BITS);
                        v[2] = v[2] + smul_shift(nx, ka, NORM_BITS);
                        v[3] = v[3] + smul_shift(ny, ka, NORM_BITS);
                        v[4] = v[4] - smul_shift(nx, pb, NORM_BITS);
                        v[5] = v[5] - smul_shift(ny, pb, NORM_BITS);
                        v[6] = v[6] - smul_shift(nx, kb, NORM_BITS);
                        v[7] = v[7] - smul_shift(ny, kb, NORM_BITS);
                        r.status = ST_RESOLVED;
                    end
                end
            end
        end
        for (int i = 0; i < 8; i++)
            r.w[i] = clamp_word(v[i]);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic disc_pair_t make_pair(input word_t ax, ay, avx, avy,
                                             input logic [30:0] ar, am,
                                             input word_t bx, by, bvx, bvy,
                                             input logic [30:0] br, bm);
        disc_pair_t p;
        p.ax = ax; p.ay = ay; p.avx = avx; p.avy = avy; p.ar = ar; p.am = am;
        p.bx = bx; p.by = by; p.bvx = bvx; p.bvy = bvy; p.br = br; p.bm = bm;
        return p;
    endfunction

    function automatic word_t rand_scaled();
        return word_t'($signed($urandom) >>> $urandom_range(0, 31));
    endfunction

    function automatic logic [30:0] rand_mag();
        return 31'($urandom >> $urandom_range(1, 31));
    endfunction

    function automatic disc_pair_t rand_pair();
        disc_pair_t p;
        logic [31:0] rs;
        if ($urandom_range(0, 9) == 0)
            return make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        p.ax = $urandom; p.ay = $urandom;
        p.avx = rand_scaled(); p.avy = rand_scaled();
        p.bvx = rand_scaled(); p.bvy = rand_scaled();
        p.ar = rand_mag(); p.br = rand_mag();
        p.am = rand_mag(); p.bm = rand_mag();
        if ($urandom_range(0, 19) == 0) p.am = 0;
        if ($urandom_range(0, 19) == 0) p.bm = 0;
        rs = 32'(p.ar) + 32'(p.br);
        p.bx = p.ax - word_t'($urandom_range(0, rs)) + word_t'($urandom_range(0, rs) >> 1)
               + word_t'(rs >> 2);
        p.by = p.ay + word_t'($urandom_range(0, rs) >> 1) - word_t'(rs >> 2);
        if ($urandom_range(0, 15) == 0)
        begin
            p.bx = p.ax + word_t'($urandom_range(0, 200));
            p.by = p.ay;
        end
        return p;
    endfunction

    function automatic logic [IN_BITS-1:0] pack_pair(input disc_pair_t p);
        return {4'd0, p.bm, p.br, p.bvy, p.bvx, p.by, p.bx,
                p.am, p.ar, p.avy, p.avx, p.ay, p.ax};
    endfunction

    task automatic send_pair(input disc_pair_t p);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_pair(p);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_contact(p));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_RESTITUTION)
            restitution_q = val;
        else if (idx == CFG_MIN_DISTANCE)
            min_dist_q = val;
        @(posedge clk);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        localparam word_t ONE = 32'sd65536;
        localparam logic [30:0] R1 = 31'd65536;
        localparam logic [30:0] RMAX = 31'h7FFFFFFF;
        send_pair(make_pair(0, 0, 0, 0, R1, R1, 10 * ONE, 0, 0, 0, R1, R1));
        send_pair(make_pair(0, 0, ONE, 0, 0, R1, 0, 0, -ONE, 0, 0, R1));
        send_pair(make_pair(ONE, ONE, ONE, 0, R1, R1, ONE, ONE, -ONE, 0, R1, R1));
        send_pair(make_pair(50, 0, 0, 0, R1, R1, 0, 0, -ONE, 0, R1, R1));
        send_pair(make_pair(0, 0, -ONE, 0, R1, R1, ONE, 0, ONE, 0, R1, R1));
        send_pair(make_pair(0, 0, ONE, 0, R1, R1, ONE, 0, -ONE, 0, R1, 2 * R1));
        send_pair(make_pair(0, 0, 0, 0, R1, R1, ONE, ONE / 2, 0, 0, R1, R1));
        send_pair(make_pair(0, 0, ONE, 0, R1, 0, ONE, 0, -ONE, 0, R1, R1));
        send_pair(make_pair(0, 0, ONE, 0, R1, R1, ONE, 0, -ONE, 0, R1, 0));
        send_pair(make_pair(ONE, ONE, ONE, ONE, R1, 3 * R1, 0, 0, -ONE, 0, R1, R1));
        send_pair(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, RMAX, RMAX,
                            32'h7FFF0000, 32'h7FFF8000, 32'h80000000, 32'h80000000, RMAX, RMAX));
        send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, RMAX, 1,
                            32'h80010000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, RMAX, 1));
        send_pair(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, RMAX, RMAX,
                            32'h80000010, 32'h80000010, 0, 0, RMAX, RMAX));
        send_pair(make_pair(32'h7FFFFFFF, 0, 0, 0, RMAX, RMAX, 32'h80000000, 0, 0, 0, RMAX, RMAX));
        send_pair(make_pair(0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 1, 1));
        drain();
        write_reg(CFG_RESTITUTION, 17'd0);
        write_reg(CFG_MIN_DISTANCE, 17'd0);
        write_reg(2'd2, 17'h1FFFF);
        write_reg(2'd3, 17'h1FFFF);
        send_pair(make_pair(0, 0, ONE, 0, R1, R1, 0, 0, -ONE, 0, R1, R1));
        send_pair(make_pair(0, 0, ONE, 0, R1, R1, 1, 0, -ONE, 0, R1, R1));
        send_pair(make_pair(0, 0, ONE, 0, R1, R1, ONE, 0, -ONE, 0, R1, R1));
        drain();
        write_reg(CFG_RESTITUTION, 17'h1FFFF);
        write_reg(CFG_MIN_DISTANCE, 17'h1FFFF);
        send_pair(make_pair(0, 0, ONE, ONE, 4 * R1, R1, ONE, 0, -ONE, 0, R1, R1));
        send_pair(make_pair(0, 0, ONE, ONE, 4 * R1, R1, 3 * ONE, 0, -ONE, 0, R1, R1));
        drain();
    endtask

    task automatic test_random(input int n, input logic [CFG_BITS-1:0] rest,
                               input logic [CFG_BITS-1:0] mind);
        write_reg(CFG_RESTITUTION, rest);
        write_reg(CFG_MIN_DISTANCE, mind);
        gaps_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++)
            send_pair(rand_pair());
        drain();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_kick = 1'b1;
        for (int i = 0; i < 160; i++)
            send_pair(rand_pair());
        drain();
    endtask

    // ---------------- receiver and checker ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_kick && hold_count < HOLD_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else if (stall_on)
        begin
            m_axis_tready <= (cycles % 23 < 15) ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        contact_result_t e;
        logic bad;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("disc_collision_impulse_unit_tb: FAIL");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: data %h status %0d", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                e = pending_results.pop_front();
                bad = (m_axis_tuser != e.status);
                for (int i = 0; i < 8; i++)
                    if (m_axis_tdata[32 * i +: 32] !== e.w[i])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: status exp %0d got %0d", e.status, m_axis_tuser);
                        for (int i = 0; i < 8; i++)
                            $display("  word %0d exp %h got %h", i, e.w[i],
                                     m_axis_tdata[32 * i +: 32]);
                    end
                end
            end
        end
    end

    initial
    begin
        burst_left = 0;
        gaps_on = 1'b0;
        stall_on = 1'b0;
        hold_kick = 1'b0;
        restitution_q = RESTITUTION_RESET;
        min_dist_q = MIN_DISTANCE_RESET;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(350, RESTITUTION_RESET, MIN_DISTANCE_RESET);
        test_random(300, 17'd0, 17'd0);
        test_backpressure();
        test_random(300, 17'd65536, 17'd65536);
        test_random(300, 17'h1FFFF, 17'h1FFFF);
        test_random(350, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 4096)));
        if (mismatches == 0 && pending_results.size() == 0)
            $display("disc_collision_impulse_unit_tb: PASS");
        else
            $display("disc_collision_impulse_unit_tb: FAIL");
        $finish;
    end

endmodule
